/* hdl/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg: shared definitions for the DDA line rasterizer
// Default widths, register indexes, reset values, sequencer states and the
// control bundles that pass between the sequencer and its shared units.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int ADDR_W   = 32;
  localparam int COLOR_W  = 32;
  localparam int FRAME_W  = 13;
  localparam int STRIDE_W = 16;
  localparam int BPP_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd4;

  localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RST  = 13'd800;
  localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RST = 13'd600;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST   = 16'd3200;
  localparam logic [BPP_W-1:0]    BYTES_PER_PX_RST = 4'd4;
  localparam logic [ADDR_W-1:0]   FRAME_BASE_RST   = 32'd0;

  // input item opcodes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X_GO,
    ST_DIV_X_RUN,
    ST_DIV_Y_GO,
    ST_DIV_Y_RUN,
    ST_ADDR_ROW,
    ST_ADDR_COL,
    ST_PUSH
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   mult_a;
    logic [STRIDE_W-1:0] mult_b;
    logic [ADDR_W-1:0]   addend;
  } mac_cmd_t;

endpackage

/* hdl/dlr_if.sv */
// ----------------------------------------------------------------------------
// dlr_if: channel bundles of the DDA line rasterizer
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface dlr_in_if #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [31:0]                  draw_color;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, draw_color,
                  input ready);
  modport sink (input valid, mode, start_x, start_y, end_x, end_y, draw_color,
                output ready);
  modport mon (input valid, ready, mode, start_x, start_y, end_x, end_y, draw_color);
endinterface

interface dlr_out_if #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         on_screen;
  logic [31:0]                  pixel_address;
  logic [31:0]                  pixel_color;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, on_screen, pixel_address,
                  pixel_color, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, on_screen, pixel_address,
                pixel_color, last_pixel, output ready);
  modport mon (input valid, ready, pixel_x, pixel_y, on_screen, pixel_address,
               pixel_color, last_pixel);
endinterface

interface dlr_cfg_if ();
  logic                                 valid;
  logic                                 ready;
  logic [dlr_pkg::CFG_IDX_W-1:0]        index;
  logic [dlr_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport mon (input valid, ready, index, data);
endinterface

/* hdl/dlr_divider.sv */
// ----------------------------------------------------------------------------
// dlr_divider: shared restoring divider, one quotient bit per cycle
// Computes floor((dividend << FRAC_BITS) / divisor) for dividend <= divisor,
// giving FRAC_BITS+1 quotient bits.
// ----------------------------------------------------------------------------
module dlr_divider #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [COORD_BITS-1:0]   dividend_i,
  input  logic [COORD_BITS-1:0]   divisor_i,
  output dlr_pkg::div_status_t    status_o,
  output logic [FRAC_BITS:0]      quotient_o
);
  import dlr_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(FRAC_BITS);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] div_q, div_d;
  logic [FRAC_BITS-1:0]  quo_q, quo_d;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  // first step compares the remainder as is, later steps shift in a zero
  always_comb begin
    trial = (cnt_q == CNT_START) ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff  = trial - {1'b0, div_q};
    ge    = ~diff[COORD_BITS];
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_START;
      rem_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      quo_d = {quo_q[FRAC_BITS-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (cnt_q == '0);
  assign quotient_o    = {quo_q, ge};

endmodule

/* hdl/dlr_mac.sv */
// ----------------------------------------------------------------------------
// dlr_mac: shared multiply-add unit for pixel addresses
// Registers addend + mult_a * mult_b, kept modulo 2^32.
// ----------------------------------------------------------------------------
module dlr_mac (
  input  logic                      clk_i,
  input  dlr_pkg::mac_cmd_t         cmd_i,
  output logic [dlr_pkg::ADDR_W-1:0] result_o
);
  import dlr_pkg::*;

  logic [ADDR_W+STRIDE_W-1:0] prod;
  logic [ADDR_W-1:0]          result_q, result_d;

  always_comb begin
    prod     = cmd_i.mult_a * cmd_i.mult_b;
    result_d = cmd_i.addend + prod[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

/* hdl/dda_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer: DDA line generator with framebuffer addressing
// A load beat sets up a line from two endpoints and a color; each advance
// beat on an active line yields one rounded, frame-tested, addressed pixel.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-----------------------------------------
//  in_i     | in  | valid / ready   | mode, start_x, start_y, end_x, end_y,
//           |     |                 | draw_color
//  out_o    | out | valid / ready   | pixel_x, pixel_y, on_screen,
//           |     |                 | pixel_address, pixel_color, last_pixel
//  cfg_i    | in  | valid / ready   | index, data (ready is always high)
//
//  Advance beat: accept, row multiply, column multiply, push into the
//  output register; the push waits while that register is full. Both
//  multiplies go through the shared multiply-add unit.
//  Load beat: in_i.ready stays low after the accept while the
//  bit-serial divider runs once for x and once for y.
//  A stalled result sits in the output register; the block keeps working and
//  only waits in the push step when that register is still full.
//  Reset clears the sequencer, the active-line flag and output valid and
//  loads the frame registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlr_in_if.sink    in_i,
  dlr_out_if.source out_o,
  dlr_cfg_if.sink   cfg_i
);
  import dlr_pkg::*;

  localparam int ACC_W = COORD_BITS + FRAC_BITS;
  localparam int INC_W = FRAC_BITS + 2;
  localparam int PX_W  = COORD_BITS + 1;
  localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);

  // --------------------------------------------------------------------------
  // Frame configuration registers
  // --------------------------------------------------------------------------
  logic [FRAME_W-1:0]  frame_width_q;
  logic [FRAME_W-1:0]  frame_height_q;
  logic [STRIDE_W-1:0] row_stride_q;
  logic [BPP_W-1:0]    bytes_per_px_q;
  logic [ADDR_W-1:0]   frame_base_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      row_stride_q   <= ROW_STRIDE_RST;
      bytes_per_px_q <= BYTES_PER_PX_RST;
      frame_base_q   <= FRAME_BASE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_i.data[FRAME_W-1:0];
        REG_ROW_STRIDE:   row_stride_q   <= cfg_i.data[STRIDE_W-1:0];
        REG_BYTES_PER_PX: bytes_per_px_q <= cfg_i.data[BPP_W-1:0];
        REG_FRAME_BASE:   frame_base_q   <= cfg_i.data[ADDR_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and handshake
  // --------------------------------------------------------------------------
  seq_state_e  state_q, state_d;
  div_status_t div_status;
  logic        in_acc;
  logic        load_acc;
  logic        adv_acc;
  logic        out_load;
  logic        out_valid_q;
  logic        active_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_acc   = in_acc && (in_i.mode == MODE_LOAD);
  // an advance on an idle line is consumed without a result
  assign adv_acc    = in_acc && (in_i.mode == MODE_ADVANCE) && active_q;
  // push once the output register is free or drains this cycle
  assign out_load   = (state_q == ST_PUSH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load_acc) begin
          state_d = ST_DIV_X_GO;
        end else if (adv_acc) begin
          state_d = ST_ADDR_ROW;
        end
      end
      ST_DIV_X_GO:  state_d = ST_DIV_X_RUN;
      ST_DIV_X_RUN: if (div_status.done) state_d = ST_DIV_Y_GO;
      ST_DIV_Y_GO:  state_d = ST_DIV_Y_RUN;
      ST_DIV_Y_RUN: if (div_status.done) state_d = ST_IDLE;
      ST_ADDR_ROW:  state_d = ST_ADDR_COL;
      ST_ADDR_COL:  state_d = ST_PUSH;
      ST_PUSH:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Load setup: deltas, step count, start accumulators
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0]        ax_full, ay_full;
  logic [COORD_BITS-1:0]      ax, ay, steps;

  always_comb begin
    dx      = {in_i.end_x[COORD_BITS-1], in_i.end_x}
            - {in_i.start_x[COORD_BITS-1], in_i.start_x};
    dy      = {in_i.end_y[COORD_BITS-1], in_i.end_y}
            - {in_i.start_y[COORD_BITS-1], in_i.start_y};
    ax_full = dx[COORD_BITS] ? -dx : dx;
    ay_full = dy[COORD_BITS] ? -dy : dy;
    ax      = ax_full[COORD_BITS-1:0];
    ay      = ay_full[COORD_BITS-1:0];
    steps   = (ax > ay) ? ax : ay;
  end

  logic [COORD_BITS-1:0] ax_q, ay_q, steps_q;
  logic                  x_neg_q, y_neg_q;

  // --------------------------------------------------------------------------
  // Shared divider: x increment first, then y
  // --------------------------------------------------------------------------
  logic                  div_start;
  logic [COORD_BITS-1:0] div_dividend;
  logic [FRAC_BITS:0]    div_quot;
  logic [FRAC_BITS:0]    quot_fix;
  logic                  quot_neg;
  logic [INC_W-1:0]      inc_new;

  always_comb begin
    div_start    = (state_q == ST_DIV_X_GO) || (state_q == ST_DIV_Y_GO);
    div_dividend = (state_q == ST_DIV_X_GO) ? ax_q : ay_q;
  end

  dlr_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dlr_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (steps_q),
    .status_o   (div_status),
    .quotient_o (div_quot)
  );

  // a zero-length line keeps both increments at zero
  always_comb begin
    quot_fix = (steps_q == '0) ? '0 : div_quot;
    quot_neg = (state_q == ST_DIV_X_RUN) ? x_neg_q : y_neg_q;
    inc_new  = quot_neg ? -{1'b0, quot_fix} : {1'b0, quot_fix};
  end

  // --------------------------------------------------------------------------
  // Line state and per-pixel rounding
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0]      x_acc_q, y_acc_q;
  logic [INC_W-1:0]      x_inc_q, y_inc_q;
  logic [COORD_BITS:0]   pixels_left_q;
  logic [COLOR_W-1:0]    color_q;

  logic [ACC_W:0]        x_round, y_round;
  logic [PX_W-1:0]       px, py;
  logic [ADDR_W-1:0]     px_ext, py_ext;
  logic                  vis;
  logic                  last;

  // floor(acc + 1/2): arithmetic shift of the biased accumulator
  always_comb begin
    x_round = {x_acc_q[ACC_W-1], x_acc_q} + HALF;
    y_round = {y_acc_q[ACC_W-1], y_acc_q} + HALF;
    px      = x_round[ACC_W:FRAC_BITS];
    py      = y_round[ACC_W:FRAC_BITS];
    px_ext  = {{(ADDR_W-PX_W){px[PX_W-1]}}, px};
    py_ext  = {{(ADDR_W-PX_W){py[PX_W-1]}}, py};
    vis     = !px[PX_W-1] && !py[PX_W-1]
           && (px_ext < ADDR_W'(frame_width_q))
           && (py_ext < ADDR_W'(frame_height_q));
    last    = (pixels_left_q == (COORD_BITS+1)'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (load_acc) begin
      active_q <= 1'b1;
    end else if (adv_acc && last) begin
      active_q <= 1'b0;
    end
  end

  logic [PX_W-1:0] px_q, py_q;
  logic            vis_q, last_q;

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      x_acc_q       <= {in_i.start_x, {FRAC_BITS{1'b0}}};
      y_acc_q       <= {in_i.start_y, {FRAC_BITS{1'b0}}};
      pixels_left_q <= {1'b0, steps} + (COORD_BITS+1)'(1);
      color_q       <= in_i.draw_color;
      ax_q          <= ax;
      ay_q          <= ay;
      steps_q       <= steps;
      x_neg_q       <= dx[COORD_BITS];
      y_neg_q       <= dy[COORD_BITS];
    end else if (adv_acc) begin
      // advance the accumulators past the pixel just taken
      x_acc_q       <= x_acc_q + {{(ACC_W-INC_W){x_inc_q[INC_W-1]}}, x_inc_q};
      y_acc_q       <= y_acc_q + {{(ACC_W-INC_W){y_inc_q[INC_W-1]}}, y_inc_q};
      pixels_left_q <= pixels_left_q - (COORD_BITS+1)'(1);
      px_q          <= px;
      py_q          <= py;
      vis_q         <= vis;
      last_q        <= last;
    end
    if ((state_q == ST_DIV_X_RUN) && div_status.done) begin
      x_inc_q <= inc_new;
    end
    if ((state_q == ST_DIV_Y_RUN) && div_status.done) begin
      y_inc_q <= inc_new;
    end
  end

  // --------------------------------------------------------------------------
  // Address: base + row * stride, then + column * bytes per pixel
  // --------------------------------------------------------------------------
  mac_cmd_t          mac_cmd;
  logic [ADDR_W-1:0] mac_result;

  always_comb begin
    mac_cmd.en     = (state_q == ST_ADDR_ROW) || (state_q == ST_ADDR_COL);
    mac_cmd.mult_a = {{(ADDR_W-PX_W){py_q[PX_W-1]}}, py_q};
    mac_cmd.mult_b = row_stride_q;
    mac_cmd.addend = frame_base_q;
    if (state_q == ST_ADDR_COL) begin
      mac_cmd.mult_a = {{(ADDR_W-PX_W){px_q[PX_W-1]}}, px_q};
      mac_cmd.mult_b = STRIDE_W'(bytes_per_px_q);
      mac_cmd.addend = mac_result;
    end
  end

  dlr_mac u_dlr_mac (
    .clk_i    (clk_i),
    .cmd_i    (mac_cmd),
    .result_o (mac_result)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [COORD_BITS-1:0] out_px_q, out_py_q;
  logic                  out_vis_q, out_last_q;
  logic [ADDR_W-1:0]     out_addr_q;
  logic [COLOR_W-1:0]    out_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_px_q    <= px_q[COORD_BITS-1:0];
      out_py_q    <= py_q[COORD_BITS-1:0];
      out_vis_q   <= vis_q;
      out_last_q  <= last_q;
      out_addr_q  <= mac_result;
      out_color_q <= color_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_x       = out_px_q;
  assign out_o.pixel_y       = out_py_q;
  assign out_o.on_screen     = out_vis_q;
  assign out_o.pixel_address = out_addr_q;
  assign out_o.pixel_color   = out_color_q;
  assign out_o.last_pixel    = out_last_q;

endmodule

/* hdl/dlr_checker.sv */
// ----------------------------------------------------------------------------
// dlr_checker: port-level checks for the DDA line rasterizer
// Watches the input and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dlr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_mode_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [dlr_pkg::ADDR_W-1:0]  out_addr_i
);
  import dlr_pkg::*;

  // a load starts the divider, so the input side must go busy
  a_load_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_mode_i == MODE_LOAD)) |=> !in_ready_i)
    else $error("input still ready right after a load beat");

  // results are pushed only from a busy step, never straight from idle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a busy cycle before it");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_addr_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_addr_i))
    else $error("result address changed while stalled");

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_addr_i  (out_o.pixel_address)
);
